[rtl/core/tti_pkg.sv]
// ----------------------------------------------------------------------------
// Trilinear table interpolator package
// Shared codes, item type and state encodings of the interpolator.
// ----------------------------------------------------------------------------
package tti_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned ADDR_W    = 12;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned GAP_W     = DATA_W + 1;

  localparam logic [CMD_W-1:0] CMD_WR_X   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_Y   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WR_Z   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WR_TBL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_X_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_POINTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_POINTS = 2'd2;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic [2:0] {
    CLS_WR_X,
    CLS_WR_Y,
    CLS_WR_Z,
    CLS_WR_TBL,
    CLS_QUERY
  } cls_e;

  typedef struct packed {
    cls_e                     cls;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] wdata;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_RD_HI,
    ST_CLAMP,
    ST_SRCH,
    ST_NEXT,
    ST_IDX0,
    ST_IDX1,
    ST_TRD,
    ST_TCAP,
    ST_LRP,
    ST_LWAIT,
    ST_OUT
  } bk_st_e;

  typedef enum logic [2:0] {
    L_IDLE,
    L_DIV,
    L_SLOPE,
    L_MUL,
    L_ADD,
    L_FIN
  } lrp_st_e;

endpackage

[rtl/core/tti_front.sv]
// ----------------------------------------------------------------------------
// Interpolator front end
// Accepts input items, decodes the command into an item class, drops unused
// commands and holds up to two items for the back end.
// ----------------------------------------------------------------------------
module tti_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [tti_pkg::CMD_W-1:0]        cmd_i,
  input  logic [tti_pkg::ADDR_W-1:0]       addr_i,
  input  logic signed [tti_pkg::DATA_W-1:0] wdata_i,
  input  logic signed [tti_pkg::DATA_W-1:0] x_in_i,
  input  logic signed [tti_pkg::DATA_W-1:0] y_in_i,
  input  logic signed [tti_pkg::DATA_W-1:0] z_in_i,
  output logic                             q_valid_o,
  output tti_pkg::item_t                   q_item_o,
  input  logic                             q_ready_i
);
  import tti_pkg::*;

  item_t      slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic       known;
  cls_e       cls;
  logic       push, pop;

  always_comb begin
    known = 1'b1;
    cls   = CLS_QUERY;
    case (cmd_i)
      CMD_WR_X:   cls = CLS_WR_X;
      CMD_WR_Y:   cls = CLS_WR_Y;
      CMD_WR_Z:   cls = CLS_WR_Z;
      CMD_WR_TBL: cls = CLS_WR_TBL;
      CMD_QUERY:  cls = CLS_QUERY;
      default:    known = 1'b0;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  // Unused commands complete their transfer but never enter the queue.
  assign push = in_valid_i && in_ready_o && known;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    cnt_d    = cnt_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{cls: cls, addr: addr_i, wdata: wdata_i,
                            x: x_in_i, y: y_in_i, z: z_in_i};
    end
  end

endmodule

[rtl/core/tti_lerp.sv]
// ----------------------------------------------------------------------------
// Interpolator linear step unit
// Computes start + slope * offset with slope = (end - start) / gap through a
// bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tti_lerp #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned VW          = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [VW-1:0]               a_i,
  input  logic signed [VW-1:0]               b_i,
  input  logic signed [tti_pkg::GAP_W-1:0]   off_i,
  input  logic signed [tti_pkg::GAP_W-1:0]   gap_i,
  output logic                               done_o,
  output logic signed [VW-1:0]               res_o
);
  import tti_pkg::*;

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned QW = VW + FRAC_W + 1;
  localparam int unsigned DG = GAP_W;
  localparam int unsigned CW = $clog2(QW + 1);
  localparam int unsigned PW = W + GAP_W;
  localparam int unsigned SW = VW + FRAC_W + 2;
  localparam logic [QW-1:0] QLIM = {{(QW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W - 1){1'b0}}};

  lrp_st_e st_q, st_d;

  logic signed [VW-1:0]    a_q, a_d;
  logic signed [DG-1:0]    off_q, off_d;
  logic [QW-1:0]           num_q, num_d;
  logic [DG:0]             rem_q, rem_d;
  logic [DG-1:0]           den_q, den_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    neg_q, neg_d;
  logic                    zgap_q, zgap_d;
  logic                    dvneg_q, dvneg_d;
  logic                    dvzero_q, dvzero_d;
  logic signed [W-1:0]     slope_q, slope_d;
  logic signed [PW-1:0]    prod_q, prod_d;
  logic signed [VW-1:0]    res_q, res_d;

  logic signed [VW:0]      dv;
  logic [VW:0]             dvm;
  logic [DG-1:0]           gm;
  logic [DG:0]             rem_sh;
  logic                    ge;
  logic signed [SW-1:0]    sum;

  always_comb begin
    st_d = st_q;
    case (st_q)
      L_IDLE: begin
        if (start_i) begin
          st_d = (gap_i == '0) ? L_SLOPE : L_DIV;
        end
      end
      L_DIV: begin
        if (cnt_q == CW'(QW - 1)) begin
          st_d = L_SLOPE;
        end
      end
      L_SLOPE: st_d = L_MUL;
      L_MUL:   st_d = L_ADD;
      L_ADD:   st_d = L_FIN;
      L_FIN:   st_d = L_IDLE;
      default: st_d = L_IDLE;
    endcase
  end

  always_comb begin
    a_d      = a_q;
    off_d    = off_q;
    num_d    = num_q;
    rem_d    = rem_q;
    den_d    = den_q;
    cnt_d    = cnt_q;
    neg_d    = neg_q;
    zgap_d   = zgap_q;
    dvneg_d  = dvneg_q;
    dvzero_d = dvzero_q;
    slope_d  = slope_q;
    prod_d   = prod_q;
    res_d    = res_q;

    dv     = (VW + 1)'(b_i) - (VW + 1)'(a_i);
    dvm    = dv[VW] ? (VW + 1)'(-dv) : (VW + 1)'(dv);
    gm     = gap_i[DG-1] ? DG'(-gap_i) : DG'(gap_i);
    rem_sh = {rem_q[DG-1:0], num_q[QW-1]};
    ge     = (rem_sh >= {1'b0, den_q});
    sum    = SW'(a_q) + SW'($signed(prod_q[PW-1:FRAC_W]));

    case (st_q)
      L_IDLE: begin
        if (start_i) begin
          a_d      = a_i;
          off_d    = off_i;
          num_d    = {dvm, {FRAC_W{1'b0}}};
          rem_d    = '0;
          den_d    = gm;
          cnt_d    = '0;
          neg_d    = dv[VW] ^ gap_i[DG-1];
          zgap_d   = (gap_i == '0);
          dvneg_d  = dv[VW];
          dvzero_d = (dv == '0);
        end
      end
      L_DIV: begin
        rem_d = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
        num_d = {num_q[QW-2:0], ge};
        cnt_d = cnt_q + CW'(1);
      end
      L_SLOPE: begin
        if (zgap_q) begin
          slope_d = dvzero_q ? '0 : (dvneg_q ? VMIN : VMAX);
        end else if (!neg_q) begin
          slope_d = (num_q > QLIM) ? VMAX : $signed(num_q[W-1:0]);
        end else begin
          slope_d = (num_q > (QLIM + QW'(1))) ? VMIN : $signed(W'(-num_q[W-1:0]));
        end
      end
      L_MUL: begin
        prod_d = slope_q * off_q;
      end
      L_ADD: begin
        if (sum > SW'(VMAX)) begin
          res_d = VW'(VMAX);
        end else if (sum < SW'(VMIN)) begin
          res_d = VW'(VMIN);
        end else begin
          res_d = VW'($signed(sum[W-1:0]));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= L_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    off_q    <= off_d;
    num_q    <= num_d;
    rem_q    <= rem_d;
    den_q    <= den_d;
    cnt_q    <= cnt_d;
    neg_q    <= neg_d;
    zgap_q   <= zgap_d;
    dvneg_q  <= dvneg_d;
    dvzero_q <= dvzero_d;
    slope_q  <= slope_d;
    prod_q   <= prod_d;
    res_q    <= res_d;
  end

  assign done_o = (st_q == L_FIN);
  assign res_o  = res_q;

endmodule

[rtl/core/tti_back.sv]
// ----------------------------------------------------------------------------
// Interpolator back end
// Holds the breakpoint and table memories, carries out writes and runs the
// query sequence: clamp, cell search, corner fetch and seven linear steps.
// ----------------------------------------------------------------------------
module tti_back #(
  parameter int unsigned MAX_X_POINTS = 16,
  parameter int unsigned MAX_Y_POINTS = 16,
  parameter int unsigned MAX_Z_POINTS = 16,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tti_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tti_pkg::CNT_W-1:0]           cfg_data_i,
  input  logic                                q_valid_i,
  input  tti_pkg::item_t                      q_item_i,
  output logic                                q_ready_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tti_pkg::DATA_W-1:0]   value_o,
  output logic                                out_of_range_o
);
  import tti_pkg::*;

  localparam int unsigned VW   = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;
  localparam int unsigned MXY  = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
  localparam int unsigned MAXM = (MXY > MAX_Z_POINTS) ? MXY : MAX_Z_POINTS;
  localparam int unsigned IW   = $clog2(MAXM);
  localparam int unsigned NW   = $clog2(MAXM + 1);
  localparam int unsigned XAW  = $clog2(MAX_X_POINTS);
  localparam int unsigned YAW  = $clog2(MAX_Y_POINTS);
  localparam int unsigned ZAW  = $clog2(MAX_Z_POINTS);
  localparam int unsigned TDEPTH = MAX_X_POINTS * MAX_Y_POINTS * MAX_Z_POINTS;
  localparam int unsigned TAW  = $clog2(TDEPTH);

  function automatic logic [NW-1:0] used_cnt(input logic [CNT_W-1:0] r,
                                             input int unsigned mx);
    if (r < CNT_W'(2)) begin
      return NW'(2);
    end else if (32'(r) > mx) begin
      return NW'(mx);
    end
    return NW'(r);
  endfunction

  // Memories.
  logic signed [DATA_W-1:0] xbr [MAX_X_POINTS];
  logic signed [DATA_W-1:0] ybr [MAX_Y_POINTS];
  logic signed [DATA_W-1:0] zbr [MAX_Z_POINTS];
  logic signed [DATA_W-1:0] tbl [TDEPTH];
  logic signed [DATA_W-1:0] xrd_q, yrd_q, zrd_q, trd_q;

  bk_st_e st_q, st_d;

  logic [CNT_W-1:0]         cfgx_q, cfgy_q, cfgz_q;
  logic [NW-1:0]            nx, ny, nz, ncur;
  logic [31:0]              a32;
  logic                     take;
  logic [IW-1:0]            ba;
  logic [TAW-1:0]           ta;
  logic signed [DATA_W-1:0] rd, coord;

  logic signed [DATA_W-1:0] xc_q, yc_q, zc_q;
  logic [1:0]               axis_q, axis_d;
  logic signed [DATA_W-1:0] v_q, v_d, lo_q, lo_d, base_q, base_d;
  logic [IW-1:0]            i_q, i_d;
  logic                     flag_q, flag_d;
  logic signed [GAP_W-1:0]  gx_q, gy_q, gz_q, ox_q, oy_q, oz_q;
  logic signed [GAP_W-1:0]  gap_n, off_n;
  logic [XAW-1:0]           ii_q;
  logic [YAW-1:0]           jj_q;
  logic [ZAW-1:0]           kk_q;
  logic [TAW-1:0]           p_q, sz_q, b_q;
  logic [2:0]               c_q, c_d;
  logic signed [DATA_W-1:0] corner_q [8];
  logic [2:0]               k_q, k_d;
  logic signed [VW-1:0]     r_q [6];

  logic                     lp_start, lp_done;
  logic signed [VW-1:0]     lp_a, lp_b, lp_res;
  logic signed [GAP_W-1:0]  lp_off, lp_gap;

  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] value_q;
  logic                     oor_q;
  logic                     load;

  assign nx   = used_cnt(cfgx_q, MAX_X_POINTS);
  assign ny   = used_cnt(cfgy_q, MAX_Y_POINTS);
  assign nz   = used_cnt(cfgz_q, MAX_Z_POINTS);
  assign a32  = 32'(q_item_i.addr);
  assign take = (st_q == ST_IDLE) && q_valid_i;
  assign q_ready_o = (st_q == ST_IDLE);

  always_comb begin
    case (axis_q)
      AX_X:    begin ncur = nx; rd = xrd_q; coord = xc_q; end
      AX_Y:    begin ncur = ny; rd = yrd_q; coord = yc_q; end
      default: begin ncur = nz; rd = zrd_q; coord = zc_q; end
    endcase
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i && (q_item_i.cls == CLS_QUERY)) begin
          st_d = ST_RD_LO;
        end
      end
      ST_RD_LO: st_d = ST_RD_HI;
      ST_RD_HI: st_d = ST_CLAMP;
      ST_CLAMP: st_d = ST_SRCH;
      ST_SRCH: begin
        if ((v_q >= rd) || (i_q == '0)) begin
          st_d = ST_NEXT;
        end
      end
      ST_NEXT:  st_d = (axis_q == AX_Z) ? ST_IDX0 : ST_RD_LO;
      ST_IDX0:  st_d = ST_IDX1;
      ST_IDX1:  st_d = ST_TRD;
      ST_TRD:   st_d = ST_TCAP;
      ST_TCAP:  st_d = (c_q == 3'd7) ? ST_LRP : ST_TRD;
      ST_LRP:   st_d = ST_LWAIT;
      ST_LWAIT: begin
        if (lp_done) begin
          st_d = (k_q == 3'd6) ? ST_OUT : ST_LRP;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    axis_d = axis_q;
    v_d    = v_q;
    lo_d   = lo_q;
    base_d = base_q;
    i_d    = i_q;
    flag_d = flag_q;
    c_d    = c_q;
    k_d    = k_q;
    ba     = '0;
    ta     = b_q + (c_q[2] ? sz_q : '0) + (c_q[1] ? TAW'(ny) : '0) + TAW'(c_q[0]);
    gap_n  = GAP_W'(rd) - GAP_W'(base_q);
    off_n  = GAP_W'(v_q) - GAP_W'(base_q);
    lp_start = (st_q == ST_LRP);
    load   = (st_q == ST_OUT) && (!out_valid_q || out_ready_i);

    case (st_q)
      ST_IDLE: begin
        axis_d = AX_X;
        flag_d = 1'b0;
      end
      ST_RD_LO: begin
        v_d = coord;
      end
      ST_RD_HI: begin
        lo_d = rd;
        ba   = IW'(ncur - NW'(1));
      end
      ST_CLAMP: begin
        if (v_q < lo_q) begin
          v_d    = lo_q;
          flag_d = 1'b1;
        end else if (v_q > rd) begin
          v_d    = rd;
          flag_d = 1'b1;
        end
        i_d = IW'(ncur - NW'(2));
        ba  = IW'(ncur - NW'(2));
      end
      ST_SRCH: begin
        // Walk downward from the next-to-last breakpoint; cell 0 is the fallback.
        if ((v_q >= rd) || (i_q == '0)) begin
          base_d = rd;
          ba     = i_q + IW'(1);
        end else begin
          i_d = i_q - IW'(1);
          ba  = i_q - IW'(1);
        end
      end
      ST_NEXT: begin
        axis_d = axis_q + 2'd1;
      end
      ST_IDX1: begin
        c_d = '0;
      end
      ST_TCAP: begin
        c_d = c_q + 3'd1;
        k_d = '0;
      end
      ST_LWAIT: begin
        if (lp_done) begin
          k_d = k_q + 3'd1;
        end
      end
      default: ;
    endcase
  end

  // Operand selection for the seven linear steps: four along X, two along Y,
  // one along Z.
  always_comb begin
    lp_off = ox_q;
    lp_gap = gx_q;
    case (k_q)
      3'd0: begin lp_a = VW'(corner_q[0]); lp_b = VW'(corner_q[2]); end
      3'd1: begin lp_a = VW'(corner_q[1]); lp_b = VW'(corner_q[3]); end
      3'd2: begin lp_a = VW'(corner_q[4]); lp_b = VW'(corner_q[6]); end
      3'd3: begin lp_a = VW'(corner_q[5]); lp_b = VW'(corner_q[7]); end
      3'd4: begin
        lp_a = r_q[0]; lp_b = r_q[1]; lp_off = oy_q; lp_gap = gy_q;
      end
      3'd5: begin
        lp_a = r_q[2]; lp_b = r_q[3]; lp_off = oy_q; lp_gap = gy_q;
      end
      default: begin
        lp_a = r_q[4]; lp_b = r_q[5]; lp_off = oz_q; lp_gap = gz_q;
      end
    endcase
  end

  assign out_valid_d = load || (out_valid_q && !out_ready_i);

  tti_lerp #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .VW         (VW)
  ) u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(lp_start),
    .a_i    (lp_a),
    .b_i    (lp_b),
    .off_i  (lp_off),
    .gap_i  (lp_gap),
    .done_o (lp_done),
    .res_o  (lp_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
      cfgx_q      <= CNT_W'(2);
      cfgy_q      <= CNT_W'(2);
      cfgz_q      <= CNT_W'(2);
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_X_POINTS: cfgx_q <= cfg_data_i;
          CFG_Y_POINTS: cfgy_q <= cfg_data_i;
          CFG_Z_POINTS: cfgz_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q <= axis_d;
    v_q    <= v_d;
    lo_q   <= lo_d;
    base_q <= base_d;
    i_q    <= i_d;
    flag_q <= flag_d;
    c_q    <= c_d;
    k_q    <= k_d;
    if (take && (q_item_i.cls == CLS_QUERY)) begin
      xc_q <= q_item_i.x;
      yc_q <= q_item_i.y;
      zc_q <= q_item_i.z;
    end
    if (st_q == ST_NEXT) begin
      case (axis_q)
        AX_X:    begin gx_q <= gap_n; ox_q <= off_n; ii_q <= i_q[XAW-1:0]; end
        AX_Y:    begin gy_q <= gap_n; oy_q <= off_n; jj_q <= i_q[YAW-1:0]; end
        default: begin gz_q <= gap_n; oz_q <= off_n; kk_q <= i_q[ZAW-1:0]; end
      endcase
    end
    if (st_q == ST_IDX0) begin
      p_q  <= TAW'(nx) * TAW'(kk_q) + TAW'(ii_q);
      sz_q <= TAW'(nx) * TAW'(ny);
    end
    if (st_q == ST_IDX1) begin
      b_q <= TAW'(ny) * p_q + TAW'(jj_q);
    end
    if (st_q == ST_TCAP) begin
      corner_q[c_q] <= trd_q;
    end
    if ((st_q == ST_LWAIT) && lp_done && (k_q < 3'd6)) begin
      r_q[k_q] <= lp_res;
    end
    if (load) begin
      value_q <= lp_res[DATA_W-1:0];
      oor_q   <= flag_q;
    end
  end

  // Breakpoint memories: written by write items, one registered read each.
  always_ff @(posedge clk_i) begin
    if (take && (q_item_i.cls == CLS_WR_X) && (a32 < MAX_X_POINTS)) begin
      xbr[a32[XAW-1:0]] <= q_item_i.wdata;
    end
    if (take && (q_item_i.cls == CLS_WR_Y) && (a32 < MAX_Y_POINTS)) begin
      ybr[a32[YAW-1:0]] <= q_item_i.wdata;
    end
    if (take && (q_item_i.cls == CLS_WR_Z) && (a32 < MAX_Z_POINTS)) begin
      zbr[a32[ZAW-1:0]] <= q_item_i.wdata;
    end
    xrd_q <= xbr[ba[XAW-1:0]];
    yrd_q <= ybr[ba[YAW-1:0]];
    zrd_q <= zbr[ba[ZAW-1:0]];
  end

  // Table memory.
  always_ff @(posedge clk_i) begin
    if (take && (q_item_i.cls == CLS_WR_TBL) && (a32 < TDEPTH)) begin
      tbl[a32[TAW-1:0]] <= q_item_i.wdata;
    end
    trd_q <= tbl[ta];
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = value_q;
  assign out_of_range_o = oor_q;

endmodule

[rtl/core/trilinear_table_interpolator_top.sv]
// ----------------------------------------------------------------------------
// Trilinear table interpolator
// Breakpoint and table loading plus trilinear queries on signed Q16.16 data.
// ----------------------------------------------------------------------------
// Write items are carried out by the back end as it takes them. A query runs
// a downward cell search over the breakpoints of each axis, then seven linear
// steps at the internal value width VW (32 by default); the seven steps share
// one divider that produces one quotient bit per cycle. A two-entry queue lets
// the input side keep taking items while a query runs, until the queue is
// full, and a finished result waits in an output register.
module trilinear_table_interpolator_top #(
  parameter int unsigned MAX_X_POINTS = 16,
  parameter int unsigned MAX_Y_POINTS = 16,
  parameter int unsigned MAX_Z_POINTS = 16,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tti_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tti_pkg::CNT_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [tti_pkg::CMD_W-1:0]           cmd_i,
  input  logic [tti_pkg::ADDR_W-1:0]          addr_i,
  input  logic signed [tti_pkg::DATA_W-1:0]   wdata_i,
  input  logic signed [tti_pkg::DATA_W-1:0]   x_in_i,
  input  logic signed [tti_pkg::DATA_W-1:0]   y_in_i,
  input  logic signed [tti_pkg::DATA_W-1:0]   z_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tti_pkg::DATA_W-1:0]   value_o,
  output logic                                out_of_range_o
);
  import tti_pkg::*;

  logic  q_valid, q_ready;
  item_t q_item;

  tti_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .cmd_i     (cmd_i),
    .addr_i    (addr_i),
    .wdata_i   (wdata_i),
    .x_in_i    (x_in_i),
    .y_in_i    (y_in_i),
    .z_in_i    (z_in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_ready_i (q_ready)
  );

  tti_back #(
    .MAX_X_POINTS(MAX_X_POINTS),
    .MAX_Y_POINTS(MAX_Y_POINTS),
    .MAX_Z_POINTS(MAX_Z_POINTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_ready_o     (q_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .out_of_range_o(out_of_range_o)
  );

endmodule

[rtl/core/tti_checker.sv]
// ----------------------------------------------------------------------------
// Interpolator port checker
// Watches the top-level ports for result handshake and reset behavior.
// ----------------------------------------------------------------------------
module tti_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [tti_pkg::DATA_W-1:0] value_o,
  input logic                              out_of_range_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before its transfer");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(value_o) && $stable(out_of_range_o))
    else $error("result payload changed while stalled");

  // Right after reset the queue is empty and no result is pending.
  a_rst_ready: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> in_ready_o)
    else $error("input not ready after reset");

  a_rst_idle: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result offered right after reset");

endmodule

bind trilinear_table_interpolator_top tti_checker u_tti_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .value_o       (value_o),
  .out_of_range_o(out_of_range_o)
);
